/* rtl/pnos_pkg.sv */
// Shared types, constants and tables of the octave-summed noise unit.
package pnos_pkg;

   localparam int TABLE_SIZE  = 256;
   localparam int MAX_OCTAVES = 8;
   localparam int HASH_COUNT  = 14;

   localparam logic [1:0] CSR_OCTAVE_COUNT = 2'd0;
   localparam logic [1:0] CSR_PERSISTENCE  = 2'd1;
   localparam logic [1:0] CSR_LACUNARITY   = 2'd2;

   localparam logic [3:0]  OCTAVE_COUNT_RESET = 4'd1;
   localparam logic [15:0] PERSISTENCE_RESET  = 16'd32768;
   localparam logic [15:0] LACUNARITY_RESET   = 16'd512;

   localparam logic [31:0] ONE_Q16_32 = 32'h0001_0000;
   localparam logic [16:0] ONE_Q16_17 = 17'h1_0000;

   typedef enum logic [5:0] {
      ST_IDLE = 6'b000001,
      ST_MUL  = 6'b000010,
      ST_USE  = 6'b000100,
      ST_READ = 6'b001000,
      ST_DIV  = 6'b010000,
      ST_OUT  = 6'b100000
   } state_type;

   typedef enum logic [4:0] {
      OP_MX  = 5'd0,
      OP_MY  = 5'd1,
      OP_MZ  = 5'd2,
      OP_FX0 = 5'd3,
      OP_FX1 = 5'd4,
      OP_FX2 = 5'd5,
      OP_FY0 = 5'd6,
      OP_FY1 = 5'd7,
      OP_FY2 = 5'd8,
      OP_FZ0 = 5'd9,
      OP_FZ1 = 5'd10,
      OP_FZ2 = 5'd11,
      OP_L0  = 5'd12,
      OP_L1  = 5'd13,
      OP_L2  = 5'd14,
      OP_L3  = 5'd15,
      OP_L4  = 5'd16,
      OP_L5  = 5'd17,
      OP_L6  = 5'd18,
      OP_TOT = 5'd19,
      OP_AMP = 5'd20,
      OP_FRQ = 5'd21
   } op_type;

   localparam logic [7:0] PERM_INIT [TABLE_SIZE] = '{
      8'd151,8'd160,8'd137,8'd91,8'd90,8'd15,8'd131,8'd13,8'd201,8'd95,8'd96,8'd53,
      8'd194,8'd233,8'd7,8'd225,8'd140,8'd36,8'd103,8'd30,8'd69,8'd142,8'd8,8'd99,
      8'd37,8'd240,8'd21,8'd10,8'd23,8'd190,8'd6,8'd148,8'd247,8'd120,8'd234,8'd75,
      8'd0,8'd26,8'd197,8'd62,8'd94,8'd252,8'd219,8'd203,8'd117,8'd35,8'd11,8'd32,
      8'd57,8'd177,8'd33,8'd88,8'd237,8'd149,8'd56,8'd87,8'd174,8'd20,8'd125,8'd136,
      8'd171,8'd168,8'd68,8'd175,8'd74,8'd165,8'd71,8'd134,8'd139,8'd48,8'd27,8'd166,
      8'd77,8'd146,8'd158,8'd231,8'd83,8'd111,8'd229,8'd122,8'd60,8'd211,8'd133,8'd230,
      8'd220,8'd105,8'd92,8'd41,8'd55,8'd46,8'd245,8'd40,8'd244,8'd102,8'd143,8'd54,
      8'd65,8'd25,8'd63,8'd161,8'd1,8'd216,8'd80,8'd73,8'd209,8'd76,8'd132,8'd187,
      8'd208,8'd89,8'd18,8'd169,8'd200,8'd196,8'd135,8'd130,8'd116,8'd188,8'd159,8'd86,
      8'd164,8'd100,8'd109,8'd198,8'd173,8'd186,8'd3,8'd64,8'd52,8'd217,8'd226,8'd250,
      8'd124,8'd123,8'd5,8'd202,8'd38,8'd147,8'd118,8'd126,8'd255,8'd82,8'd85,8'd212,
      8'd207,8'd206,8'd59,8'd227,8'd47,8'd16,8'd58,8'd17,8'd182,8'd189,8'd28,8'd42,
      8'd223,8'd183,8'd170,8'd213,8'd119,8'd248,8'd152,8'd2,8'd44,8'd154,8'd163,8'd70,
      8'd221,8'd153,8'd101,8'd155,8'd167,8'd43,8'd172,8'd9,8'd129,8'd22,8'd39,8'd253,
      8'd19,8'd98,8'd108,8'd110,8'd79,8'd113,8'd224,8'd232,8'd178,8'd185,8'd112,8'd104,
      8'd218,8'd246,8'd97,8'd228,8'd251,8'd34,8'd242,8'd193,8'd238,8'd210,8'd144,8'd12,
      8'd191,8'd179,8'd162,8'd241,8'd81,8'd51,8'd145,8'd235,8'd249,8'd14,8'd239,8'd107,
      8'd49,8'd192,8'd214,8'd31,8'd181,8'd199,8'd106,8'd157,8'd184,8'd84,8'd204,8'd176,
      8'd115,8'd121,8'd50,8'd45,8'd127,8'd4,8'd150,8'd254,8'd138,8'd236,8'd205,8'd93,
      8'd222,8'd114,8'd67,8'd29,8'd24,8'd72,8'd243,8'd141,8'd128,8'd195,8'd78,8'd66,
      8'd215,8'd61,8'd156,8'd180
   };

   // Gradient dot product selected by the low four hash bits.
   function automatic logic signed [18:0] grad_value(input logic [3:0] h,
                                                     input logic signed [17:0] x,
                                                     input logic signed [17:0] y,
                                                     input logic signed [17:0] z);
      logic signed [18:0] a;
      logic signed [18:0] b;
      a = (h < 4'd8) ? 19'(x) : 19'(y);
      if (h < 4'd4) begin
         b = 19'(y);
      end else if (h == 4'd12 || h == 4'd14) begin
         b = 19'(x);
      end else begin
         b = 19'(z);
      end
      if (h[0]) begin
         a = -a;
      end
      if (h[1]) begin
         b = -b;
      end
      return a + b;
   endfunction

endpackage

/* rtl/pnos_divider.sv */
// Restoring unsigned divider, one quotient bit per cycle.
module pnos_divider #(
   parameter int NUM_W = 42,
   parameter int DEN_W = 21
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NUM_W-1:0] dividend,
   input  logic [DEN_W-1:0] divisor,
   output logic             done,
   output logic [NUM_W-1:0] quotient
);
   localparam int CNT_W = $clog2(NUM_W + 1);

   logic             busy_ff;
   logic             done_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic [DEN_W:0]   rem_ff;
   logic [NUM_W-1:0] quo_ff;
   logic [DEN_W-1:0] den_ff;

   logic [DEN_W:0]   rem_sh;
   logic             fits;
   logic [DEN_W:0]   rem_in;

   always_comb begin
      rem_sh = {rem_ff[DEN_W-1:0], quo_ff[NUM_W-1]};
      fits   = (rem_sh >= {1'b0, den_ff});
      rem_in = fits ? (rem_sh - {1'b0, den_ff}) : rem_sh;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CNT_W'(NUM_W);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == CNT_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= '0;
         quo_ff <= dividend;
         den_ff <= divisor;
      end else if (busy_ff) begin
         rem_ff <= rem_in;
         quo_ff <= {quo_ff[NUM_W-2:0], fits};
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;
endmodule

/* rtl/perlin_noise_octave_sum_unit.sv */
// Top level of the octave-summed 3D gradient noise unit with its permutation memory.
//
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+------------------------------------------
//  req_    | in        | req_valid / req_stall   | func, coord_x/y/z, entry_index/value
//  rsp_    | out       | rsp_valid / rsp_stall   | noise_value
//  csr_    | in        | csr_write               | csr_index, csr_data
//
// Each octave runs 22 products through the one shared multiplier and fourteen serial
// hash reads of the table, and a noise word ends with a serial division; a table
// write word needs no arithmetic. The divider retires one quotient bit per cycle.
// Reset is synchronous; the table needs no clearing pass, per-entry valid bits fall
// back to the stock permutation. A stalled result waits in the output register while
// the next word is already being worked on.
module perlin_noise_octave_sum_unit #(
   parameter int MAX_OCTAVES = pnos_pkg::MAX_OCTAVES
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_func,
   input  logic signed [31:0] req_coord_x,
   input  logic signed [31:0] req_coord_y,
   input  logic signed [31:0] req_coord_z,
   input  logic [7:0]  req_entry_index,
   input  logic [7:0]  req_entry_value,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [15:0] rsp_noise_value,
   input  logic        csr_write,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_data
);
   import pnos_pkg::*;

   localparam int OCT_W  = $clog2(MAX_OCTAVES + 1);
   localparam int ASUM_W = 17 + $clog2(MAX_OCTAVES);
   localparam int TOT_W  = 38 + $clog2(MAX_OCTAVES);
   localparam int NUM_W  = TOT_W + 1;
   localparam int DEN_W  = ASUM_W + 1;
   localparam int HV_W   = $clog2(HASH_COUNT);
   localparam int RDK_W  = $clog2(HASH_COUNT + 1);

   // configuration
   logic [3:0]  octave_count_ff;
   logic [15:0] persistence_ff;
   logic [15:0] lacunarity_ff;

   // control
   state_type        state_ff;
   op_type           op_ff;
   logic [RDK_W-1:0] rd_k_ff;
   logic [OCT_W-1:0] oct_cnt_ff;
   logic [OCT_W-1:0] oct_n_ff;
   logic             rsp_valid_ff;

   // payload
   logic signed [31:0] coord_x_ff, coord_y_ff, coord_z_ff;
   logic [31:0]        freq_ff;
   logic [16:0]        amp_ff;
   logic [ASUM_W-1:0]  asum_ff;
   logic signed [TOT_W-1:0] total_ff;
   logic [7:0]         cell_x_ff, cell_y_ff, cell_z_ff;
   logic [15:0]        tx_ff, ty_ff, tz_ff;
   logic [31:0]        tt_ff;
   logic [15:0]        t3_ff;
   logic [20:0]        q_ff;
   logic [16:0]        fade_u_ff, fade_v_ff, fade_w_ff;
   logic [7:0]         hv_ff [HASH_COUNT];
   logic signed [19:0] lr_ff [7];
   logic signed [65:0] prod_ff;
   logic               neg_ff;
   logic [15:0]        res_ff;
   logic [15:0]        rsp_noise_value_ff;

   // permutation memory
   logic [7:0]            mem [TABLE_SIZE];
   logic [TABLE_SIZE-1:0] valid_ff;
   logic [7:0]            rd_mem_ff;
   logic [7:0]            rd_init_ff;
   logic                  rd_valid_ff;
   logic [7:0]            rd_addr;
   logic [7:0]            perm_rd;

   logic accept;
   logic out_free;
   logic last_oct;
   logic div_start;
   logic div_done;
   logic [NUM_W-1:0] div_quo;
   logic signed [NUM_W-1:0] num;
   logic [OCT_W-1:0] oct_n_calc;

   logic signed [32:0] mul_a, mul_b;
   logic [15:0]        t_cur;
   logic signed [17:0] gx0, gx1, gy0, gy1, gz0, gz1;
   logic signed [18:0] g6, g7, g8, g9, g10, g11, g12, g13;
   logic [16:0]        lerp_f;
   logic signed [19:0] lerp_a, lerp_b;
   logic signed [20:0] lerp_d;
   logic signed [19:0] lerp_res;
   logic [34:0]        tt6;
   logic [21:0]        q_calc;
   logic [2:0]         lr_idx;

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign last_oct  = (oct_cnt_ff == oct_n_ff - 1'b1);
   assign div_start = (state_ff == ST_USE) && (op_ff == OP_FRQ) && last_oct;

   // clamp the octave count into 1..MAX_OCTAVES
   always_comb begin
      if (octave_count_ff == 4'd0) begin
         oct_n_calc = OCT_W'(1);
      end else if (int'(octave_count_ff) > MAX_OCTAVES) begin
         oct_n_calc = OCT_W'(MAX_OCTAVES);
      end else begin
         oct_n_calc = OCT_W'(octave_count_ff);
      end
   end

   // table read address for each of the fourteen hash lookups
   always_comb begin
      case (rd_k_ff)
         4'd0:    rd_addr = cell_x_ff;
         4'd1:    rd_addr = cell_x_ff + 8'd1;
         4'd2:    rd_addr = hv_ff[0] + cell_y_ff;
         4'd3:    rd_addr = hv_ff[0] + cell_y_ff + 8'd1;
         4'd4:    rd_addr = hv_ff[1] + cell_y_ff;
         4'd5:    rd_addr = hv_ff[1] + cell_y_ff + 8'd1;
         4'd6:    rd_addr = hv_ff[2] + cell_z_ff;
         4'd7:    rd_addr = hv_ff[4] + cell_z_ff;
         4'd8:    rd_addr = hv_ff[3] + cell_z_ff;
         4'd9:    rd_addr = hv_ff[5] + cell_z_ff;
         4'd10:   rd_addr = hv_ff[2] + cell_z_ff + 8'd1;
         4'd11:   rd_addr = hv_ff[4] + cell_z_ff + 8'd1;
         4'd12:   rd_addr = hv_ff[3] + cell_z_ff + 8'd1;
         4'd13:   rd_addr = hv_ff[5] + cell_z_ff + 8'd1;
         default: rd_addr = cell_x_ff;
      endcase
   end

   assign perm_rd = rd_valid_ff ? rd_mem_ff : rd_init_ff;

   always_ff @(posedge clock) begin
      if (accept && req_func) begin
         mem[req_entry_index] <= req_entry_value;
      end
      rd_mem_ff  <= mem[rd_addr];
      rd_init_ff <= PERM_INIT[rd_addr];
      rd_valid_ff <= valid_ff[rd_addr];
   end

   // an entry never written reads as the stock permutation
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (accept && req_func) begin
         valid_ff[req_entry_index] <= 1'b1;
      end
   end

   // corner offsets: fraction and fraction minus one
   always_comb begin
      gx0 = {2'b00, tx_ff};
      gx1 = {2'b11, tx_ff};
      gy0 = {2'b00, ty_ff};
      gy1 = {2'b11, ty_ff};
      gz0 = {2'b00, tz_ff};
      gz1 = {2'b11, tz_ff};
      g6  = grad_value(hv_ff[6][3:0],  gx0, gy0, gz0);
      g7  = grad_value(hv_ff[7][3:0],  gx1, gy0, gz0);
      g8  = grad_value(hv_ff[8][3:0],  gx0, gy1, gz0);
      g9  = grad_value(hv_ff[9][3:0],  gx1, gy1, gz0);
      g10 = grad_value(hv_ff[10][3:0], gx0, gy0, gz1);
      g11 = grad_value(hv_ff[11][3:0], gx1, gy0, gz1);
      g12 = grad_value(hv_ff[12][3:0], gx0, gy1, gz1);
      g13 = grad_value(hv_ff[13][3:0], gx1, gy1, gz1);
   end

   // blend operands of the seven interpolations
   always_comb begin
      lerp_f = fade_u_ff;
      lerp_a = '0;
      lerp_b = '0;
      case (op_ff)
         OP_L0: begin
            lerp_a = 20'(g6);
            lerp_b = 20'(g7);
         end
         OP_L1: begin
            lerp_a = 20'(g8);
            lerp_b = 20'(g9);
         end
         OP_L2: begin
            lerp_f = fade_v_ff;
            lerp_a = lr_ff[0];
            lerp_b = lr_ff[1];
         end
         OP_L3: begin
            lerp_a = 20'(g10);
            lerp_b = 20'(g11);
         end
         OP_L4: begin
            lerp_a = 20'(g12);
            lerp_b = 20'(g13);
         end
         OP_L5: begin
            lerp_f = fade_v_ff;
            lerp_a = lr_ff[3];
            lerp_b = lr_ff[4];
         end
         OP_L6: begin
            lerp_f = fade_w_ff;
            lerp_a = lr_ff[2];
            lerp_b = lr_ff[5];
         end
         default: begin
            lerp_f = fade_u_ff;
         end
      endcase
      lerp_d   = 21'(lerp_b) - 21'(lerp_a);
      // floor shift of the signed product
      lerp_res = lerp_a + prod_ff[35:16];
      lr_idx   = 3'(op_ff - OP_L0);
   end

   // fraction of the axis whose fade is in progress
   always_comb begin
      case (op_ff)
         OP_FY0, OP_FY1, OP_FY2: t_cur = ty_ff;
         OP_FZ0, OP_FZ1, OP_FZ2: t_cur = tz_ff;
         default:                t_cur = tx_ff;
      endcase
      tt6    = {1'b0, prod_ff[31:0], 2'b00} + {2'b00, prod_ff[31:0], 1'b0};
      q_calc = 22'd655360 + 22'(tt6[34:16]) - (22'({t_cur, 4'b0000}) - 22'(t_cur));
   end

   // operand select of the shared multiplier
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (op_ff)
         OP_MX: begin
            mul_a = 33'(coord_x_ff);
            mul_b = {1'b0, freq_ff};
         end
         OP_MY: begin
            mul_a = 33'(coord_y_ff);
            mul_b = {1'b0, freq_ff};
         end
         OP_MZ: begin
            mul_a = 33'(coord_z_ff);
            mul_b = {1'b0, freq_ff};
         end
         OP_FX0, OP_FY0, OP_FZ0: begin
            mul_a = {17'd0, t_cur};
            mul_b = {17'd0, t_cur};
         end
         OP_FX1, OP_FY1, OP_FZ1: begin
            mul_a = {17'd0, tt_ff[31:16]};
            mul_b = {17'd0, t_cur};
         end
         OP_FX2, OP_FY2, OP_FZ2: begin
            mul_a = {17'd0, t3_ff};
            mul_b = {12'd0, q_ff};
         end
         OP_L0, OP_L1, OP_L2, OP_L3, OP_L4, OP_L5, OP_L6: begin
            mul_a = {16'd0, lerp_f};
            mul_b = 33'(lerp_d);
         end
         OP_TOT: begin
            mul_a = 33'(lr_ff[6]);
            mul_b = {16'd0, amp_ff};
         end
         OP_AMP: begin
            mul_a = {16'd0, amp_ff};
            mul_b = {17'd0, persistence_ff};
         end
         OP_FRQ: begin
            mul_a = {1'b0, freq_ff};
            mul_b = {17'd0, lacunarity_ff};
         end
         default: begin
            mul_a = '0;
         end
      endcase
   end

   // weighted sum lifted by the amplitude sum, then halved against it
   assign num = NUM_W'(total_ff) + NUM_W'({asum_ff, 16'd0});

   pnos_divider #(
      .NUM_W (NUM_W),
      .DEN_W (DEN_W)
   ) u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (num),
      .divisor  ({asum_ff, 1'b0}),
      .done     (div_done),
      .quotient (div_quo)
   );

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         octave_count_ff <= OCTAVE_COUNT_RESET;
         persistence_ff  <= PERSISTENCE_RESET;
         lacunarity_ff   <= LACUNARITY_RESET;
      end else if (csr_write) begin
         case (csr_index)
            CSR_OCTAVE_COUNT: octave_count_ff <= csr_data[3:0];
            CSR_PERSISTENCE:  persistence_ff  <= csr_data;
            CSR_LACUNARITY:   lacunarity_ff   <= csr_data;
            default:          octave_count_ff <= octave_count_ff;
         endcase
      end
   end

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         op_ff        <= OP_MX;
         rd_k_ff      <= '0;
         oct_cnt_ff   <= '0;
         oct_n_ff     <= OCT_W'(1);
         rsp_valid_ff <= 1'b0;
      end else begin
         // load a finished word, or drop the one just taken
         if (state_ff == ST_OUT && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  oct_cnt_ff <= '0;
                  oct_n_ff   <= oct_n_calc;
                  op_ff      <= OP_MX;
                  state_ff   <= req_func ? ST_OUT : ST_MUL;
               end
            end
            ST_MUL: begin
               state_ff <= ST_USE;
            end
            ST_USE: begin
               case (op_ff)
                  OP_MZ: begin
                     rd_k_ff  <= '0;
                     state_ff <= ST_READ;
                  end
                  OP_FRQ: begin
                     if (last_oct) begin
                        state_ff <= ST_DIV;
                     end else begin
                        oct_cnt_ff <= oct_cnt_ff + 1'b1;
                        op_ff      <= OP_MX;
                        state_ff   <= ST_MUL;
                     end
                  end
                  default: begin
                     op_ff    <= op_type'(op_ff + 5'd1);
                     state_ff <= ST_MUL;
                  end
               endcase
            end
            ST_READ: begin
               if (rd_k_ff == RDK_W'(HASH_COUNT)) begin
                  op_ff    <= OP_FX0;
                  state_ff <= ST_MUL;
               end else begin
                  rd_k_ff <= rd_k_ff + 1'b1;
               end
            end
            ST_DIV: begin
               if (div_done) begin
                  state_ff <= ST_OUT;
               end
            end
            ST_OUT: begin
               // hold until the output register frees up
               if (out_free) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      prod_ff <= mul_a * mul_b;
      if (state_ff == ST_OUT && out_free) begin
         rsp_noise_value_ff <= res_ff;
      end
      if (accept) begin
         coord_x_ff <= req_coord_x;
         coord_y_ff <= req_coord_y;
         coord_z_ff <= req_coord_z;
         freq_ff    <= ONE_Q16_32;
         amp_ff     <= ONE_Q16_17;
         asum_ff    <= '0;
         total_ff   <= '0;
         res_ff     <= '0;
      end
      if (state_ff == ST_READ && rd_k_ff != '0) begin
         hv_ff[HV_W'(rd_k_ff - 1'b1)] <= perm_rd;
      end
      if (div_start) begin
         neg_ff <= num[NUM_W-1];
      end
      if (state_ff == ST_DIV && div_done) begin
         // drop negative sums to zero, saturate the top
         if (neg_ff) begin
            res_ff <= '0;
         end else if (|div_quo[NUM_W-1:16]) begin
            res_ff <= 16'hFFFF;
         end else begin
            res_ff <= div_quo[15:0];
         end
      end
      if (state_ff == ST_USE) begin
         case (op_ff)
            OP_MX: begin
               cell_x_ff <= prod_ff[39:32];
               tx_ff     <= prod_ff[31:16];
            end
            OP_MY: begin
               cell_y_ff <= prod_ff[39:32];
               ty_ff     <= prod_ff[31:16];
            end
            OP_MZ: begin
               cell_z_ff <= prod_ff[39:32];
               tz_ff     <= prod_ff[31:16];
            end
            OP_FX0, OP_FY0, OP_FZ0: begin
               tt_ff <= prod_ff[31:0];
               q_ff  <= q_calc[20:0];
            end
            OP_FX1, OP_FY1, OP_FZ1: begin
               t3_ff <= prod_ff[31:16];
            end
            OP_FX2: fade_u_ff <= prod_ff[32:16];
            OP_FY2: fade_v_ff <= prod_ff[32:16];
            OP_FZ2: fade_w_ff <= prod_ff[32:16];
            OP_L0, OP_L1, OP_L2, OP_L3, OP_L4, OP_L5, OP_L6: begin
               lr_ff[lr_idx] <= lerp_res;
            end
            OP_TOT: begin
               total_ff <= total_ff + TOT_W'(prod_ff);
               asum_ff  <= asum_ff + ASUM_W'(amp_ff);
            end
            OP_AMP: begin
               amp_ff <= prod_ff[32:16];
            end
            OP_FRQ: begin
               // saturate the frequency at all ones
               freq_ff <= (|prod_ff[47:40]) ? 32'hFFFF_FFFF : prod_ff[39:8];
            end
            default: begin
               tt_ff <= tt_ff;
            end
         endcase
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_noise_value = rsp_noise_value_ff;
endmodule

/* dv/noise_result_checker.sv */
// Watches the noise unit's channels, predicts each result and compares it with the block's.
`timescale 1ns / 1ps
module noise_result_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic        req_func,
   input  logic [31:0] req_coord_x,
   input  logic [31:0] req_coord_y,
   input  logic [31:0] req_coord_z,
   input  logic [7:0]  req_entry_index,
   input  logic [7:0]  req_entry_value,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [15:0] rsp_noise_value,
   input  logic        csr_write,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_data,
   output int          fail_count,
   output int          pending,
   output int          checked_count
);
   import pnos_pkg::*;

   logic [7:0]  perm_mem [TABLE_SIZE];
   logic [3:0]  octave_cfg;
   logic [15:0] persist_cfg;
   logic [15:0] lacun_cfg;
   logic [15:0] expected_noise [$];

   function automatic longint fade_q16(longint t);
      longint t3;
      longint q;
      t3 = (((t * t) >>> 16) * t) >>> 16;
      q  = 655360 + ((6 * t * t) >>> 16) - 15 * t;
      return (t3 * q) >>> 16;
   endfunction

   function automatic longint lerp_q16(longint f, longint a, longint b);
      return a + ((f * (b - a)) >>> 16);
   endfunction

   function automatic longint grad_dot(logic [7:0] hash, longint x, longint y, longint z);
      logic [3:0] h;
      longint a;
      longint b;
      h = hash[3:0];
      a = (h < 8) ? x : y;
      b = (h < 4) ? y : ((h == 12 || h == 14) ? x : z);
      if (h[0]) a = -a;
      if (h[1]) b = -b;
      return a + b;
   endfunction

   function automatic logic [7:0] perm_at(logic [31:0] i);
      return perm_mem[i[7:0]];
   endfunction

   function automatic longint octave_noise(logic [63:0] px, logic [63:0] py, logic [63:0] pz);
      logic [31:0] cx, cy, cz, a, b, aa, ab, ba, bb;
      longint x, y, z, x1, y1, z1, u, v, w, n0, n1;
      cx = px[39:32];
      cy = py[39:32];
      cz = pz[39:32];
      x = px[31:16];
      y = py[31:16];
      z = pz[31:16];
      x1 = x - 65536;
      y1 = y - 65536;
      z1 = z - 65536;
      u = fade_q16(x);
      v = fade_q16(y);
      w = fade_q16(z);
      a  = perm_at(cx) + cy;
      aa = perm_at(a) + cz;
      ab = perm_at(a + 1) + cz;
      b  = perm_at(cx + 1) + cy;
      ba = perm_at(b) + cz;
      bb = perm_at(b + 1) + cz;
      n0 = lerp_q16(v,
              lerp_q16(u, grad_dot(perm_at(aa), x, y, z), grad_dot(perm_at(ba), x1, y, z)),
              lerp_q16(u, grad_dot(perm_at(ab), x, y1, z), grad_dot(perm_at(bb), x1, y1, z)));
      n1 = lerp_q16(v,
              lerp_q16(u, grad_dot(perm_at(aa + 1), x, y, z1),
                       grad_dot(perm_at(ba + 1), x1, y, z1)),
              lerp_q16(u, grad_dot(perm_at(ab + 1), x, y1, z1),
                       grad_dot(perm_at(bb + 1), x1, y1, z1)));
      return lerp_q16(w, n0, n1);
   endfunction

   function automatic logic [15:0] predict_noise_sum(logic [31:0] xc, logic [31:0] yc,
                                                     logic [31:0] zc);
      logic [63:0] xs, ys, zs, freq;
      longint amp, asum, total, num, q;
      int n;
      xs = {{32{xc[31]}}, xc};
      ys = {{32{yc[31]}}, yc};
      zs = {{32{zc[31]}}, zc};
      freq = 64'd65536;
      amp = 65536;
      asum = 0;
      total = 0;
      n = octave_cfg;
      if (n < 1) n = 1;
      if (n > MAX_OCTAVES) n = MAX_OCTAVES;
      for (int i = 0; i < n; i++) begin
         total += octave_noise(xs * freq, ys * freq, zs * freq) * amp;
         asum += amp;
         amp = (amp * persist_cfg) >>> 16;
         freq = (freq * lacun_cfg) >> 8;
         if (freq > 64'hFFFF_FFFF) freq = 64'hFFFF_FFFF;
      end
      num = total + asum * 65536;
      if (num < 0) begin
         q = 0;
      end else begin
         q = num / (2 * asum);
         if (q > 65535) q = 65535;
      end
      return q[15:0];
   endfunction

   assign pending = expected_noise.size();

   always @(posedge clock) begin
      logic [15:0] want;
      if (reset) begin
         foreach (perm_mem[i]) perm_mem[i] = PERM_INIT[i];
         octave_cfg  = OCTAVE_COUNT_RESET;
         persist_cfg = PERSISTENCE_RESET;
         lacun_cfg   = LACUNARITY_RESET;
         expected_noise.delete();
         fail_count = 0;
         checked_count = 0;
      end else begin
         if (csr_write) begin
            case (csr_index)
               CSR_OCTAVE_COUNT: octave_cfg  = csr_data[3:0];
               CSR_PERSISTENCE:  persist_cfg = csr_data;
               CSR_LACUNARITY:   lacun_cfg   = csr_data;
               default: ;
            endcase
         end
         // pop before push: a word accepted now cannot finish on the same edge
         if (rsp_valid && !rsp_stall) begin
            checked_count++;
            if (expected_noise.size() == 0) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("%t unexpected result word %0d", $realtime, rsp_noise_value);
            end else begin
               want = expected_noise.pop_front();
               if (want !== rsp_noise_value) begin
                  fail_count++;
                  if (fail_count <= 10)
                     $display("%t noise_value mismatch: expected %0d actual %0d",
                              $realtime, want, rsp_noise_value);
               end
            end
         end
         if (req_valid && !req_stall) begin
            if (req_func) begin
               perm_mem[req_entry_index] = req_entry_value;
               expected_noise.push_back(16'd0);
            end else begin
               expected_noise.push_back(predict_noise_sum(req_coord_x, req_coord_y,
                                                          req_coord_z));
            end
         end
      end
   end
endmodule

/* dv/perlin_noise_octave_sum_unit_tb.sv */
// Stimulus and verdict for the octave-summed noise unit; checking lives in the checker.
`timescale 1ns / 1ps
module perlin_noise_octave_sum_unit_tb;
   import pnos_pkg::*;

   localparam int CYCLE_LIMIT = 5_000_000;
   localparam int HOLD_CYCLES = 3000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic        req_func = 1'b0;
   logic [31:0] req_coord_x = '0;
   logic [31:0] req_coord_y = '0;
   logic [31:0] req_coord_z = '0;
   logic [7:0]  req_entry_index = '0;
   logic [7:0]  req_entry_value = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [15:0] rsp_noise_value;
   logic        csr_write = 1'b0;
   logic [1:0]  csr_index = CSR_OCTAVE_COUNT;
   logic [15:0] csr_data = '0;

   int  fail_count;
   int  pending;
   int  checked_count;
   int  words_sent = 0;
   int  cycle_count = 0;
   bit  idle_on = 1'b1;
   bit  hold_req = 1'b0;
   bit  hold_done = 1'b0;

   // high and low phase of a 10 ns clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   perlin_noise_octave_sum_unit u_top (
      .clock, .reset,
      .req_valid, .req_stall, .req_func,
      .req_coord_x, .req_coord_y, .req_coord_z,
      .req_entry_index, .req_entry_value,
      .rsp_valid, .rsp_stall, .rsp_noise_value,
      .csr_write, .csr_index, .csr_data
   );

   noise_result_checker u_checker (
      .clock, .reset,
      .req_valid, .req_stall, .req_func,
      .req_coord_x, .req_coord_y, .req_coord_z,
      .req_entry_index, .req_entry_value,
      .rsp_valid, .rsp_stall, .rsp_noise_value,
      .csr_write, .csr_index, .csr_data,
      .fail_count, .pending, .checked_count
   );

   // watchdog: end a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // result side: random stall bursts, plus one long hold so the block backs up
   initial begin
      forever begin
         if (hold_req && !hold_done) begin
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_done = 1'b1;
         end else if (idle_on && $urandom_range(0, 3) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 7)) @(posedge clock);
         end else begin
            rsp_stall <= 1'b0;
            repeat ($urandom_range(1, 20)) @(posedge clock);
         end
      end
   end

   // offer one word and hold it until accepted; maybe drop valid for a burst after
   task automatic send_word(bit f, logic [31:0] x, logic [31:0] y, logic [31:0] z,
                            logic [7:0] idx, logic [7:0] val);
      req_valid       <= 1'b1;
      req_func        <= f;
      req_coord_x     <= x;
      req_coord_y     <= y;
      req_coord_z     <= z;
      req_entry_index <= idx;
      req_entry_value <= val;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      words_sent++;
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 7)) @(posedge clock);
      end
   endtask

   function automatic logic [31:0] pick_coord();
      case ($urandom_range(0, 7))
         0: return 32'h7FFF_FFFF;
         1: return 32'h8000_0000;
         2: return 32'hFFFF_FFFF;
         3: return {16'($urandom), 16'hFFFF};
         4: return 32'($signed($urandom_range(0, 2048)) - 1024) <<< 12;
         default: return $urandom;
      endcase
   endfunction

   // drain, let the block settle, then write all three registers
   task automatic set_config(logic [15:0] oct, logic [15:0] pers, logic [15:0] lac);
      req_valid <= 1'b0;
      // wait for a clock edge so the checker has counted the last accepted word
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      csr_write <= 1'b1;
      csr_index <= CSR_OCTAVE_COUNT;
      csr_data  <= oct;
      @(posedge clock);
      csr_index <= CSR_PERSISTENCE;
      csr_data  <= pers;
      @(posedge clock);
      csr_index <= CSR_LACUNARITY;
      csr_data  <= lac;
      @(posedge clock);
      csr_write <= 1'b0;
   endtask

   task automatic random_words(int count);
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(0, 9) < 3)
            send_word(1'b1, $urandom, $urandom, $urandom, 8'($urandom), 8'($urandom));
         else
            send_word(1'b0, pick_coord(), pick_coord(), pick_coord(),
                      8'($urandom), 8'($urandom));
      end
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: reset settings, extreme coordinates, table writes at both ends
      send_word(1'b0, 32'h0, 32'h0, 32'h0, 8'h00, 8'h00);
      send_word(1'b0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 8'hFF, 8'hFF);
      send_word(1'b0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 8'h00, 8'hFF);
      send_word(1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF, 8'h00);
      send_word(1'b0, 32'h0000_8000, 32'h0001_4000, 32'hFFFE_C000, 8'h00, 8'h00);
      send_word(1'b0, 32'h00FF_FFFF, 32'h0100_0000, 32'hFF00_0000, 8'h00, 8'h00);
      send_word(1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'h00, 8'hFF);
      send_word(1'b1, 32'h0, 32'h0, 32'h0, 8'hFF, 8'h00);
      send_word(1'b0, 32'h0, 32'h0, 32'h0, 8'h00, 8'h00);
      send_word(1'b0, 32'h00FF_0000, 32'h00FF_0000, 32'h00FF_0000, 8'h00, 8'h00);
      send_word(1'b1, 32'h0, 32'h0, 32'h0, 8'h00, 8'd151);
      send_word(1'b1, 32'h0, 32'h0, 32'h0, 8'hFF, 8'd180);
      send_word(1'b0, 32'h0001_0000, 32'hFFFF_0000, 32'h0000_0001, 8'h00, 8'h00);
      random_words(190);

      // frequency grows fast and saturates
      set_config(16'd3, 16'hFFFF, 16'hFFFF);
      random_words(200);
      // octave count zero means one octave; zero factors
      set_config(16'd0, 16'd0, 16'd0);
      random_words(250);
      // long hold on the result side while words keep coming
      set_config(16'd2, 16'($urandom), 16'd256);
      hold_req = 1'b1;
      random_words(300);
      set_config(16'd8, 16'd32768, 16'd512);
      random_words(100);
      // count above the maximum saturates; upper csr bits are ignored
      set_config(16'hFFFF, 16'd1, 16'd1);
      random_words(80);

      // closing stretch: full throughput, no idling on either side
      idle_on = 1'b0;
      set_config(16'd1, 16'($urandom), 16'($urandom));
      random_words(500);
      set_config(16'd4, 16'($urandom), 16'($urandom_range(256, 640)));
      random_words(270);

      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (600) @(posedge clock);

      $display("sent %0d words over seven register settings, %0d results checked",
               words_sent, checked_count);
      $display("covered table writes, octave count 0 to 15 and saturating frequency");
      if (fail_count == 0 && pending == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("%0d mismatches", fail_count);
         $display("CHECKS FAILED");
      end
      $finish;
   end
endmodule

/* sim.f */
rtl/pnos_pkg.sv
rtl/pnos_divider.sv
rtl/perlin_noise_octave_sum_unit.sv
dv/noise_result_checker.sv
dv/perlin_noise_octave_sum_unit_tb.sv
